/* hw/rtl/gmbi_pkg.sv */
// gmbi_pkg: shared types and constants of the gain map bilinear interpolator.
// No dependencies; used by gmbi_coord, gain_map_bilinear_interpolator_top and the bench files.
package gmbi_pkg;

  localparam int unsigned FRAC_W   = 24;  // Q8.24 coordinate fraction
  localparam int unsigned PIX_W    = 14;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned PROD_W   = PIX_W + CFG_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned GAIN_W   = 16;  // Q4.12
  localparam int unsigned GDIFF_W  = GAIN_W + 1;
  localparam int unsigned V_W      = GAIN_W + FRAC_W;      // first blend, exact
  localparam int unsigned VDIFF_W  = V_W + 1;
  localparam int unsigned HALF_W   = FRAC_W / 2;
  localparam int unsigned PP_W     = VDIFF_W + HALF_W + 1;
  localparam int unsigned ACC_W    = V_W + FRAC_W + 2;     // final sum with sign headroom
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_INTERP = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS     = 3'd0,
    REG_GRID_COLS     = 3'd1,
    REG_PLANES_IN_USE = 3'd2,
    REG_ROW_START     = 3'd3,
    REG_ROW_STEP      = 3'd4,
    REG_COL_START     = 3'd5,
    REG_COL_STEP      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    op_e                operation;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;
    logic [4:0]         grid_row;
    logic [4:0]         grid_col;
    logic [1:0]         plane;
    logic [GAIN_W-1:0]  gain_value;
  } in_word_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic               invalid;
  } out_word_t;

  // head of the pipe, up to the table access
  typedef struct packed {
    logic               valid;
    logic               interp;
    logic               invalid;
    logic [1:0]         plane;
    logic [4:0]         grid_row;
    logic [4:0]         grid_col;
    logic [GAIN_W-1:0]  gain_value;
  } head_ctl_t;

  // tail of the pipe, after the table access
  typedef struct packed {
    logic valid;
    logic invalid;
  } tail_ctl_t;

endpackage

/* hw/rtl/gmbi_coord.sv */
// gmbi_coord: maps a pixel offset to a clamped grid coordinate (index plus Q0.24 fraction), two stages.
// Depends on gmbi_pkg.
module gmbi_coord #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                                 clk_i,
  input  logic [gmbi_pkg::PIX_W-1:0]           offset_i,
  input  logic [gmbi_pkg::CFG_W-1:0]           start_i,
  input  logic [gmbi_pkg::CFG_W-1:0]           step_i,
  input  logic [5:0]                           points_i,
  output logic [$clog2(MAX_POINTS)-1:0]        idx_o,
  output logic [$clog2(MAX_POINTS)-1:0]        idx_hi_o,
  output logic [gmbi_pkg::FRAC_W-1:0]          frac_o
);

  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned PTW = IW + 1;
  localparam int unsigned CW  = IW + gmbi_pkg::FRAC_W;

  logic [gmbi_pkg::PROD_W-1:0] prod_q;
  logic [CW-1:0]               coord_d, coord_q;
  logic [PTW-1:0]              pts;
  logic [CW-1:0]               top;
  logic signed [gmbi_pkg::SUM_W-1:0] sum;
  logic [PTW-1:0]              nxt;

  // effective point count: zero acts as one, oversize saturates
  always_comb begin
    if (points_i == 6'd0) begin
      pts = PTW'(1);
    end else if (int'(points_i) > int'(MAX_POINTS)) begin
      pts = PTW'(MAX_POINTS);
    end else begin
      pts = PTW'(points_i);
    end
  end

  assign top = {IW'(pts - PTW'(1)), {gmbi_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    prod_q <= gmbi_pkg::PROD_W'(offset_i) * gmbi_pkg::PROD_W'(step_i);
  end

  assign sum = $signed({{(gmbi_pkg::SUM_W - gmbi_pkg::CFG_W){start_i[gmbi_pkg::CFG_W-1]}},
                        start_i})
             + $signed({2'b00, prod_q});

  always_comb begin
    if (sum <= 0) begin
      coord_d = '0;
    end else if (sum >= $signed(gmbi_pkg::SUM_W'(top))) begin
      coord_d = top;
    end else begin
      coord_d = CW'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
  end

  assign idx_o  = coord_q[CW-1:gmbi_pkg::FRAC_W];
  assign frac_o = coord_q[gmbi_pkg::FRAC_W-1:0];
  assign nxt    = PTW'(idx_o) + PTW'(1);
  assign idx_hi_o = (nxt < pts) ? IW'(nxt) : IW'(pts - PTW'(1));

endmodule

/* hw/rtl/gain_map_bilinear_interpolator_top.sv */
// Gain map bilinear interpolator, top level: eight-stage pipeline, one word per cycle.
// Only interpolate words produce a result strobe; write words give none.
// Throughput: one word (write or interpolate) every cycle; busy is never raised.
// Reset: rst_ni clears configuration to defaults and all valid bits; the gain
// table is not cleared and holds garbage until written. Results cannot be stalled.
// Depends on gmbi_pkg and gmbi_coord.
module gain_map_bilinear_interpolator_top #(
  parameter int unsigned MAX_GRID_ROWS = 32,
  parameter int unsigned MAX_GRID_COLS = 32,
  parameter int unsigned MAX_PLANES    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  gmbi_pkg::in_word_t                  in_word_i,
  input  logic                                cfg_we_i,
  input  logic [gmbi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmbi_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                                out_strobe_o,
  output gmbi_pkg::out_word_t                 out_word_o
);

  // Grid index widths. The table is split into four banks by row and column
  // parity so the four neighbours are read together, one read per bank.
  localparam int unsigned RW   = $clog2(MAX_GRID_ROWS);
  localparam int unsigned CW   = $clog2(MAX_GRID_COLS);
  localparam int unsigned PW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int unsigned RHW  = (RW > 1) ? RW - 1 : 1;
  localparam int unsigned CHW  = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned BAW  = RHW + CHW + PW;
  localparam int unsigned BANK_DEPTH = 2 ** BAW;
  localparam int unsigned FW   = gmbi_pkg::FRAC_W;
  localparam int unsigned GW   = gmbi_pkg::GAIN_W;

  // the block never holds off a word
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [5:0]                 grid_rows_q, grid_cols_q;
  logic [2:0]                 planes_in_use_q;
  logic [gmbi_pkg::CFG_W-1:0] row_start_q, row_step_q, col_start_q, col_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q     <= 6'd1;
      grid_cols_q     <= 6'd1;
      planes_in_use_q <= 3'd1;
      row_start_q     <= '0;
      row_step_q      <= '0;
      col_start_q     <= '0;
      col_step_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gmbi_pkg::REG_GRID_ROWS:     grid_rows_q     <= cfg_wdata_i[5:0];
        gmbi_pkg::REG_GRID_COLS:     grid_cols_q     <= cfg_wdata_i[5:0];
        gmbi_pkg::REG_PLANES_IN_USE: planes_in_use_q <= cfg_wdata_i[2:0];
        gmbi_pkg::REG_ROW_START:     row_start_q     <= cfg_wdata_i;
        gmbi_pkg::REG_ROW_STEP:      row_step_q      <= cfg_wdata_i;
        gmbi_pkg::REG_COL_START:     col_start_q     <= cfg_wdata_i;
        gmbi_pkg::REG_COL_STEP:      col_step_q      <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture word, plane check. Coordinate units start multiplying.
  // ---------------------------------------------------------------------
  logic                accept;
  gmbi_pkg::head_ctl_t s1_d, s1_q, s2_q;

  assign accept = start && !busy;

  always_comb begin
    s1_d            = '0;
    s1_d.valid      = accept;
    s1_d.interp     = (in_word_i.operation == gmbi_pkg::OP_INTERP);
    s1_d.invalid    = ({1'b0, in_word_i.plane} >= planes_in_use_q) ||
                      (int'(in_word_i.plane) >= int'(MAX_PLANES));
    s1_d.plane      = in_word_i.plane;
    s1_d.grid_row   = in_word_i.grid_row;
    s1_d.grid_col   = in_word_i.grid_col;
    s1_d.gain_value = in_word_i.gain_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  // Stage 2: clamped coordinates come out of the units
  logic [RW-1:0] r0, r1;
  logic [CW-1:0] c0, c1;
  logic [FW-1:0] fy, fx;

  gmbi_coord #(.MAX_POINTS(MAX_GRID_ROWS)) u_row_coord (
    .clk_i    (clk_i),
    .offset_i (in_word_i.pixel_row),
    .start_i  (row_start_q),
    .step_i   (row_step_q),
    .points_i (grid_rows_q),
    .idx_o    (r0),
    .idx_hi_o (r1),
    .frac_o   (fy)
  );

  gmbi_coord #(.MAX_POINTS(MAX_GRID_COLS)) u_col_coord (
    .clk_i    (clk_i),
    .offset_i (in_word_i.pixel_col),
    .start_i  (col_start_q),
    .step_i   (col_step_q),
    .points_i (grid_cols_q),
    .idx_o    (c0),
    .idx_hi_o (c1),
    .frac_o   (fx)
  );

  // ---------------------------------------------------------------------
  // Gain table, four parity banks. Writes and reads both happen with the
  // word in stage 2, so table order follows word order.
  // ---------------------------------------------------------------------
  logic [RW-1:0]  wr_row;
  logic [CW-1:0]  wr_col;
  logic           wr_ok;
  logic [1:0]     wr_bank;
  logic [BAW-1:0] wr_addr;
  logic [BAW-1:0] rd_addr [4];
  logic [GW-1:0]  rd_q    [4];

  assign wr_row  = RW'(s2_q.grid_row);
  assign wr_col  = CW'(s2_q.grid_col);
  assign wr_ok   = s2_q.valid && !s2_q.interp &&
                   (int'(s2_q.grid_row) < int'(MAX_GRID_ROWS)) &&
                   (int'(s2_q.grid_col) < int'(MAX_GRID_COLS)) &&
                   (int'(s2_q.plane) < int'(MAX_PLANES));
  assign wr_bank = {wr_row[0], wr_col[0]};
  assign wr_addr = {RHW'(wr_row >> 1), CHW'(wr_col >> 1), PW'(s2_q.plane)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic [GW-1:0] mem [BANK_DEPTH];
    logic [GW-1:0] rd_data_q;
    logic [RW-1:0] rsel;
    logic [CW-1:0] csel;

    // bank holds row parity BSEL[1], column parity BSEL[0]
    assign rsel = (r0[0] == BSEL[1]) ? r0 : r1;
    assign csel = (c0[0] == BSEL[0]) ? c0 : c1;
    assign rd_addr[b] = {RHW'(rsel >> 1), CHW'(csel >> 1), PW'(s2_q.plane)};

    always_ff @(posedge clk_i) begin
      if (wr_ok && (wr_bank == BSEL)) begin
        mem[wr_addr] <= s2_q.gain_value;
      end
      rd_data_q <= mem[rd_addr[b]];
    end

    assign rd_q[b] = rd_data_q;
  end

  // Stage 3: read data registered; keep parities and fractions alongside
  gmbi_pkg::tail_ctl_t s3_q, s4_q, s5_q, s6_q, s7_q;
  logic          r0p_q, r1p_q, c0p_q, c1p_q;
  logic [FW-1:0] fy3_q, fx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q.valid   <= s2_q.valid && s2_q.interp;
      s3_q.invalid <= s2_q.invalid;
    end
  end

  always_ff @(posedge clk_i) begin
    r0p_q <= r0[0];
    r1p_q <= r1[0];
    c0p_q <= c0[0];
    c1p_q <= c1[0];
    fy3_q <= fy;
    fx3_q <= fx;
  end

  // ---------------------------------------------------------------------
  // Stage 4: route banks to the four neighbours, take vertical differences
  // ---------------------------------------------------------------------
  logic [GW-1:0]                      q00, q10, q01, q11;
  logic [GW-1:0]                      q00_q, q01_q;
  logic signed [gmbi_pkg::GDIFF_W-1:0] d0_q, d1_q;
  logic [FW-1:0]                      fy4_q, fx4_q;

  assign q00 = rd_q[{r0p_q, c0p_q}];
  assign q10 = rd_q[{r1p_q, c0p_q}];
  assign q01 = rd_q[{r0p_q, c1p_q}];
  assign q11 = rd_q[{r1p_q, c1p_q}];

  always_ff @(posedge clk_i) begin
    q00_q <= q00;
    q01_q <= q01;
    d0_q  <= $signed({1'b0, q10}) - $signed({1'b0, q00});
    d1_q  <= $signed({1'b0, q11}) - $signed({1'b0, q01});
    fy4_q <= fy3_q;
    fx4_q <= fx3_q;
  end

  // Stage 5: vertical blend, v = q_top * 2^24 + (q_bot - q_top) * fy, exact
  localparam int unsigned VW  = gmbi_pkg::V_W;
  localparam int unsigned VXW = gmbi_pkg::GDIFF_W + FW + 1;

  logic signed [VXW-1:0] v0_x, v1_x;
  logic [VW-1:0]         v0_q, v1_q;
  logic [FW-1:0]         fx5_q;

  assign v0_x = $signed({2'b00, q00_q, {FW{1'b0}}}) + d0_q * $signed({1'b0, fy4_q});
  assign v1_x = $signed({2'b00, q01_q, {FW{1'b0}}}) + d1_q * $signed({1'b0, fy4_q});

  always_ff @(posedge clk_i) begin
    v0_q  <= VW'(v0_x);
    v1_q  <= VW'(v1_x);
    fx5_q <= fx4_q;
  end

  // Stage 6: horizontal difference
  logic signed [gmbi_pkg::VDIFF_W-1:0] dv_q;
  logic [VW-1:0]                       v0_6_q;
  logic [FW-1:0]                       fx6_q;

  always_ff @(posedge clk_i) begin
    dv_q   <= $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
    v0_6_q <= v0_q;
    fx6_q  <= fx5_q;
  end

  // Stage 7: dv * fx as two half-width partial products
  localparam int unsigned HW = gmbi_pkg::HALF_W;

  logic signed [gmbi_pkg::PP_W-1:0] pp_hi_q, pp_lo_q;
  logic [VW-1:0]                    v0_7_q;

  always_ff @(posedge clk_i) begin
    pp_hi_q <= dv_q * $signed({1'b0, fx6_q[FW-1:HW]});
    pp_lo_q <= dv_q * $signed({1'b0, fx6_q[HW-1:0]});
    v0_7_q  <= v0_6_q;
  end

  // Stage 8: sum, round half up at 2^-48, cut to Q4.12
  localparam int unsigned AW = gmbi_pkg::ACC_W;

  logic signed [AW-1:0] acc;
  logic [GW-1:0]        gain;

  assign acc = $signed({2'b00, v0_7_q, {FW{1'b0}}})
             + ($signed(AW'(pp_hi_q)) <<< HW)
             + $signed(AW'(pp_lo_q))
             + $signed(AW'(1) <<< (2 * FW - 1));
  // never above 0xFFFF once rounded, so the top slice is the gain
  assign gain = acc[2*FW+GW-1:2*FW];

  // pipe control for stages 4 to 7 and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q         <= '0;
      s5_q         <= '0;
      s6_q         <= '0;
      s7_q         <= '0;
      out_strobe_o <= 1'b0;
    end else begin
      s4_q         <= s3_q;
      s5_q         <= s4_q;
      s6_q         <= s5_q;
      s7_q         <= s6_q;
      out_strobe_o <= s7_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_o.gain    <= s7_q.invalid ? '0 : gain;
    out_word_o.invalid <= s7_q.invalid;
  end

endmodule

/* bench/gmbi_gain_checker.sv */
`timescale 1ns / 100ps
// gmbi_gain_checker: predicts the gain words of the interpolator from the words and
// register writes it observes, and compares them with the result words. Needs gmbi_pkg.
module gmbi_gain_checker
  import gmbi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  in_word_t         in_word_i,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             out_strobe_i,
  input  out_word_t        out_word_i,
  output int               fail_count_o,
  output int               waiting_o
);

  localparam int unsigned ROWS_MAX   = 32;
  localparam int unsigned COLS_MAX   = 32;
  localparam int unsigned PLANES_MAX = 4;
  localparam logic [63:0] UNIT       = 64'd1 << FRAC_W;

  logic [GAIN_W-1:0] grid_gains [ROWS_MAX*COLS_MAX*PLANES_MAX];
  logic [5:0]        grid_rows = 6'd1;
  logic [5:0]        grid_cols = 6'd1;
  logic [2:0]        planes_in_use = 3'd1;
  logic [31:0]       row_start = '0;
  logic [31:0]       row_step = '0;
  logic [31:0]       col_start = '0;
  logic [31:0]       col_step = '0;
  out_word_t         expected_gains [$];
  int                mismatches = 0;

  function automatic int unsigned slot(int unsigned r, int unsigned c, int unsigned p);
    return (r * COLS_MAX + c) * PLANES_MAX + p;
  endfunction

  // zero acts as one point, oversize saturates
  function automatic int unsigned span_points(logic [5:0] n, int unsigned limit);
    if (n == 0) return 1;
    if (32'(n) > limit) return limit;
    return 32'(n);
  endfunction

  // Q8.24 grid coordinate, clamped to [0, points-1]
  function automatic logic [63:0] grid_position(logic [31:0] origin, logic [31:0] pitch,
                                                logic [PIX_W-1:0] offset,
                                                int unsigned points);
    logic signed [63:0] pos;
    logic signed [63:0] top;
    pos = {{32{origin[31]}}, origin} + 64'(offset) * 64'(pitch);
    top = 64'(points - 1) << FRAC_W;
    if (pos <= 0) return '0;
    if (pos >= top) return top;
    return pos;
  endfunction

  function automatic out_word_t blend_gain(logic [PIX_W-1:0] prow, logic [PIX_W-1:0] pcol,
                                           logic [1:0] plane);
    out_word_t   res;
    int unsigned rows, cols, r0, r1, c0, c1;
    logic [63:0] ry, cx, fy, fx, q00, q01, q10, q11, v0, v1, acc;
    res.gain    = '0;
    res.invalid = 1'b1;
    if (plane >= planes_in_use || 32'(plane) >= PLANES_MAX) return res;
    rows = span_points(grid_rows, ROWS_MAX);
    cols = span_points(grid_cols, COLS_MAX);
    ry   = grid_position(row_start, row_step, prow, rows);
    cx   = grid_position(col_start, col_step, pcol, cols);
    r0   = 32'(ry >> FRAC_W);
    c0   = 32'(cx >> FRAC_W);
    r1   = (r0 + 1 < rows) ? r0 + 1 : rows - 1;
    c1   = (c0 + 1 < cols) ? c0 + 1 : cols - 1;
    fy   = ry & (UNIT - 1);
    fx   = cx & (UNIT - 1);
    q00  = 64'(grid_gains[slot(r0, c0, 32'(plane))]);
    q10  = 64'(grid_gains[slot(r1, c0, 32'(plane))]);
    q01  = 64'(grid_gains[slot(r0, c1, 32'(plane))]);
    q11  = 64'(grid_gains[slot(r1, c1, 32'(plane))]);
    v0   = q00 * (UNIT - fy) + q10 * fy;
    v1   = q01 * (UNIT - fy) + q11 * fy;
    acc  = v0 * (UNIT - fx) + v1 * fx;
    // single rounding, half up, from 48 fraction bits
    acc  = (acc + (64'd1 << (2 * FRAC_W - 1))) >> (2 * FRAC_W);
    res.gain    = (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
    res.invalid = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      grid_rows     = 6'd1;
      grid_cols     = 6'd1;
      planes_in_use = 3'd1;
      row_start     = '0;
      row_step      = '0;
      col_start     = '0;
      col_step      = '0;
      expected_gains.delete();
      waiting_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_ROWS:     grid_rows     = cfg_wdata_i[5:0];
          REG_GRID_COLS:     grid_cols     = cfg_wdata_i[5:0];
          REG_PLANES_IN_USE: planes_in_use = cfg_wdata_i[2:0];
          REG_ROW_START:     row_start     = cfg_wdata_i;
          REG_ROW_STEP:      row_step      = cfg_wdata_i;
          REG_COL_START:     col_start     = cfg_wdata_i;
          REG_COL_STEP:      col_step      = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (in_word_i.operation == OP_WRITE) begin
          grid_gains[slot(32'(in_word_i.grid_row), 32'(in_word_i.grid_col),
                          32'(in_word_i.plane))] = in_word_i.gain_value;
        end else begin
          expected_gains = {expected_gains,
                            blend_gain(in_word_i.pixel_row, in_word_i.pixel_col,
                                       in_word_i.plane)};
        end
      end
      if (out_strobe_i) begin
        if (expected_gains.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word: gain %h invalid %b",
                     $time, out_word_i.gain, out_word_i.invalid);
        end else begin
          want = expected_gains.pop_front();
          if (out_word_i.gain !== want.gain || out_word_i.invalid !== want.invalid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: gain %h invalid %b, expected gain %h invalid %b",
                       $time, out_word_i.gain, out_word_i.invalid, want.gain, want.invalid);
          end
        end
      end
      waiting_o <= expected_gains.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

/* bench/gain_map_bilinear_interpolator_top_tb.sv */
`timescale 1ns / 100ps
// gain_map_bilinear_interpolator_top_tb: stimulus and verdict for the interpolator.
// Depends on gmbi_pkg, gmbi_gain_checker and gain_map_bilinear_interpolator_top.
module gain_map_bilinear_interpolator_top_tb;
  import gmbi_pkg::*;

  localparam int unsigned PIPE_DEPTH   = 8;       // pipeline stages of the interpolator
  localparam int unsigned CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int unsigned RANDOM_WORDS = 20;      // per phase; nine phases
  localparam logic [31:0] ONE_Q24      = 32'h0100_0000;
  localparam logic [31:0] HALF_Q24     = 32'h0080_0000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         in_word = '0;
  logic             cfg_we = 1'b0;
  cfg_reg_e         cfg_idx = REG_GRID_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             out_strobe;
  out_word_t        out_word;
  int               fail_count;
  int               waiting;
  int unsigned      cycles = 0;

  // Stimulus-side copy of the grid in force, so that interpolations only ever touch
  // entries that have been loaded.
  int unsigned rows_used = 1;
  int unsigned cols_used = 1;
  int unsigned planes_used = 1;
  int unsigned row_span = 16383;
  int unsigned col_span = 16383;
  int unsigned gap_pct = 22;   // chance in a hundred, per draw, that the sender idles instead of offering a word

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gain_map_bilinear_interpolator_top_tb failed");
      $finish;
    end
  end

  gain_map_bilinear_interpolator_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .in_word_i    (in_word),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .out_strobe_o (out_strobe),
    .out_word_o   (out_word)
  );

  gmbi_gain_checker gain_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .in_word_i    (in_word),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .out_strobe_i (out_strobe),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  // Grid write word; pixel fields are don't-care and get random content.
  function automatic in_word_t gain_write(int unsigned r, int unsigned c, int unsigned p,
                                          logic [GAIN_W-1:0] g);
    in_word_t w;
    w.operation  = OP_WRITE;
    w.pixel_row  = PIX_W'($urandom);
    w.pixel_col  = PIX_W'($urandom);
    w.grid_row   = 5'(r);
    w.grid_col   = 5'(c);
    w.plane      = 2'(p);
    w.gain_value = g;
    return w;
  endfunction

  // Interpolate word; grid fields and gain are don't-care.
  function automatic in_word_t gain_lookup(int unsigned prow, int unsigned pcol,
                                           int unsigned p);
    in_word_t w;
    w.operation  = OP_INTERP;
    w.pixel_row  = PIX_W'(prow);
    w.pixel_col  = PIX_W'(pcol);
    w.grid_row   = 5'($urandom);
    w.grid_col   = 5'($urandom);
    w.plane      = 2'(p);
    w.gain_value = GAIN_W'($urandom);
    return w;
  endfunction

  // Step that walks the whole grid over 'span' pixels.
  function automatic logic [31:0] step_across(int unsigned points, int unsigned span);
    return 32'((64'(points - 1) << FRAC_W) / span);
  endfunction

  // Origin within one grid point either side of zero; negative half covers the clamp.
  function automatic logic [31:0] random_origin();
    return 32'($urandom_range(0, 2 * ONE_Q24)) - ONE_Q24;
  endfunction

  // Mostly inside the span (plus a little overshoot), now and then the full range.
  function automatic int unsigned pick_pixel(int unsigned span);
    int unsigned hi;
    hi = span + span / 8;
    if (hi > 16383) hi = 16383;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16383);
    return $urandom_range(0, hi);
  endfunction

  // Offer one word; start stays high into the next word when there is no gap.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender until every expected word has come back, then let any write
  // still in the pipe retire before registers move.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] rows_val, cols_val, planes_val,
                               input logic [31:0] rs, rstep, cs, cstep);
    write_reg(REG_GRID_ROWS, rows_val);
    write_reg(REG_GRID_COLS, cols_val);
    write_reg(REG_PLANES_IN_USE, planes_val);
    write_reg(REG_ROW_START, rs);
    write_reg(REG_ROW_STEP, rstep);
    write_reg(REG_COL_START, cs);
    write_reg(REG_COL_STEP, cstep);
    cfg_we <= 1'b0;
    // mirror the block's masking, zero-as-one and saturation
    rows_used   = (rows_val[5:0] == 0) ? 1 : (rows_val[5:0] > 32) ? 32 : 32'(rows_val[5:0]);
    cols_used   = (cols_val[5:0] == 0) ? 1 : (cols_val[5:0] > 32) ? 32 : 32'(cols_val[5:0]);
    planes_used = (planes_val[2:0] > 4) ? 4 : 32'(planes_val[2:0]);
  endtask

  // Fill every entry the current grid can read, with random gains.
  task automatic load_grid();
    for (int r = 0; r < rows_used; r++)
      for (int c = 0; c < cols_used; c++)
        for (int p = 0; p < planes_used; p++)
          send_word(gain_write(r, c, p, GAIN_W'($urandom)));
  endtask

  initial begin
    int unsigned r_pts, c_pts, p_cnt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: 1x1 grid, one plane, zero steps.
    send_word(gain_write(0, 0, 0, 16'hFFFF));
    send_word(gain_lookup(0, 0, 0));
    send_word(gain_lookup(16383, 16383, 0));   // zero step: same point everywhere
    send_word(gain_lookup(0, 0, 1));           // plane not in use
    send_word(gain_lookup(5, 5, 3));
    send_word(gain_write(31, 31, 3, 16'h0000)); // write field extremes, plane beyond in-use
    send_word(gain_write(0, 0, 0, 16'h0000));
    send_word(gain_lookup(0, 0, 0));

    // Directed, 2x2 grid: half a grid point per pixel row, columns from -0.5.
    drain();
    apply_setting(2, 2, 4, 32'h0, HALF_Q24, 32'h0 - HALF_Q24, ONE_Q24);
    send_word(gain_write(0, 0, 1, 16'h0000));
    send_word(gain_write(1, 0, 1, 16'h0001));
    send_word(gain_write(0, 1, 1, 16'hFFFF));
    send_word(gain_write(1, 1, 1, 16'h1000));
    send_word(gain_lookup(0, 0, 1));           // low clamp on columns
    send_word(gain_lookup(1, 1, 1));           // centre of the four
    send_word(gain_lookup(1, 0, 1));           // exact half: rounds up
    send_word(gain_lookup(1, 2, 1));           // top clamp on columns
    send_word(gain_lookup(16383, 16383, 1));   // both axes clamped to the far corner

    // Random phases: sender gaps 22%, then 63%, then none; each phase with its own grid.
    for (int ph = 0; ph < 9; ph++) begin
      gap_pct  = (ph < 3) ? 22 : (ph < 6) ? 63 : 0;
      drain();
      row_span = $urandom_range(1, 16383);
      col_span = $urandom_range(1, 16383);
      case (ph)
        0: apply_setting(32, 2, 1, 32'h0 - HALF_Q24, step_across(32, row_span),
                         32'h7FFF_FFFF, 32'h0);
        1: apply_setting(2, 32, 1, 32'h8000_0000, 32'hFFFF_FFFF,
                         random_origin(), step_across(32, col_span));
        // oversized rows saturate, zero columns act as one, planes above four cap
        2: apply_setting(63, 0, 7, random_origin(), step_across(32, row_span),
                         random_origin(), 32'h0);
        // upper bits of the size are dropped; no plane in use, so all invalid
        3: apply_setting(32'h45, 6, 0, random_origin(), step_across(5, row_span),
                         random_origin(), step_across(6, col_span));
        default: begin
          r_pts = $urandom_range(1, 4);
          c_pts = $urandom_range(1, 4);
          p_cnt = $urandom_range(1, 4);
          apply_setting(r_pts, c_pts, p_cnt, random_origin(), step_across(r_pts, row_span),
                        random_origin(), step_across(c_pts, col_span));
        end
      endcase
      load_grid();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        if ($urandom_range(0, 99) < 2) drain();
        if ($urandom_range(0, 3) == 0)
          send_word(gain_write($urandom_range(0, 31), $urandom_range(0, 31),
                               $urandom_range(0, 3), GAIN_W'($urandom)));
        else
          send_word(gain_lookup(pick_pixel(row_span), pick_pixel(col_span),
                                (planes_used != 0 && $urandom_range(0, 4) != 0) ?
                                  $urandom_range(0, planes_used - 1) :
                                  $urandom_range(0, 3)));
      end
    end

    drain();
    if (fail_count == 0 && waiting == 0)
      $display("gain_map_bilinear_interpolator_top_tb passed");
    else
      $display("gain_map_bilinear_interpolator_top_tb failed");
    $finish;
  end

endmodule
